>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define QFIR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QFIR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/qfir_pkg.sv
// Shared types, constants and helpers for the Q15 FIR filter.
// No dependencies; used by the interfaces and every module of the block.
package qfir_pkg;

  localparam int MAX_TAPS = 64;
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] acc_t;
  typedef logic [6:0]         tap_cfg_t;
  typedef logic [5:0]         coef_idx_t;

  // Input word kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam tap_cfg_t TAP_COUNT_RST = 7'd64;
  localparam acc_t     ACC_INIT      = 32'sh0000_4000;
  localparam acc_t     ACC_MAX       = 32'sh7FFF_FFFF;
  localparam acc_t     ACC_MIN       = 32'sh8000_0000;

  // Control that travels with each tap through the datapath
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // Clamp the configured tap count to 1..MAX_TAPS
  function automatic cnt_t eff_taps(input tap_cfg_t t);
    cnt_t n;
    if (t == '0) begin
      n = cnt_t'(1);
    end else if (int'(t) > MAX_TAPS) begin
      n = cnt_t'(MAX_TAPS);
    end else begin
      n = cnt_t'(t);
    end
    return n;
  endfunction

endpackage

>>> hdl/qfir_if.sv
// Valid/ready channel interfaces for the Q15 FIR filter: input, result, config.
// Depends on qfir_pkg.
interface qfir_in_if;
  import qfir_pkg::*;
  logic      valid;
  logic      ready;
  logic      mode;
  coef_idx_t coef_index;
  sample_t   value;
  modport source(output valid, mode, coef_index, value, input ready);
  modport sink(input valid, mode, coef_index, value, output ready);
endinterface

interface qfir_out_if;
  import qfir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t filtered;
  modport source(output valid, filtered, input ready);
  modport sink(input valid, filtered, output ready);
endinterface

interface qfir_cfg_if;
  import qfir_pkg::*;
  logic     valid;
  logic     ready;
  tap_cfg_t tap_count;
  modport source(output valid, tap_count, input ready);
  modport sink(input valid, tap_count, output ready);
endinterface

>>> hdl/q15_fir_filter.sv
// Q15 direct-form FIR filter, one multiply-accumulate per cycle from tap memories.
// A sample holds the input off until its result is in the output register;
// if the output stalls, the result waits until the register is free.
// A coefficient word does not hold the input off. The tap loop over the memories sets the rate.
// Synchronous reset: tap count returns to 64, delay line and coefficients read as zero.
module q15_fir_filter (
  input  logic        clk,
  input  logic        rst_n,
  qfir_cfg_if.sink    cfg_ch,
  qfir_in_if.sink     in_ch,
  qfir_out_if.source  out_ch
);
  import qfir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WAIT_OUT
  } state_t;

  state_t   state_r;
  tap_cfg_t tap_count_r;
  cnt_t     n_r;
  addr_t    iss_r;
  logic     out_valid_r;
  sample_t  filtered_r;

  logic     in_acc;
  logic     smp_acc;
  logic     coef_we;
  logic     last_iss;
  logic     out_free;
  logic     out_load;
  mac_ctl_t rd_ctl;
  mac_ctl_t tap_ctl;
  sample_t  tap_sample;
  sample_t  tap_coef;
  logic     mac_done;
  sample_t  mac_result;

  assign cfg_ch.ready    = 1'b1;
  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = filtered_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign smp_acc  = in_acc && (in_ch.mode == MODE_SAMPLE);
  assign coef_we  = in_acc && (in_ch.mode == MODE_COEF)
                    && (int'(in_ch.coef_index) < MAX_TAPS);
  assign last_iss = (cnt_t'(iss_r) + cnt_t'(1)) == n_r;
  assign out_free = !out_valid_r || out_ch.ready;
  // Result moves into the output register once the register is free
  assign out_load = out_free
                    && ((state_r == ST_WAIT_OUT) || ((state_r == ST_DRAIN) && mac_done));

  // Tap read issue
  assign rd_ctl.vld   = (state_r == ST_RUN);
  assign rd_ctl.first = (iss_r == '0);
  assign rd_ctl.last  = last_iss;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      tap_count_r <= cfg_ch.tap_count;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      n_r         <= cnt_t'(1);
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        filtered_r  <= mac_result;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (smp_acc) begin
            n_r     <= eff_taps(tap_count_r);
            iss_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_iss) begin
            state_r <= ST_DRAIN;
          end else begin
            iss_r <= iss_r + addr_t'(1);
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            if (out_free) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_WAIT_OUT;
            end
          end
        end
        ST_WAIT_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  qfir_tap_mem u_tap_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef_we     (coef_we),
    .coef_addr   (addr_t'(in_ch.coef_index)),
    .coef_data   (in_ch.value),
    .load_sample (smp_acc),
    .sample_data (in_ch.value),
    .rd_ctl      (rd_ctl),
    .rd_addr     (iss_r),
    .tap_ctl     (tap_ctl),
    .tap_sample  (tap_sample),
    .tap_coef    (tap_coef)
  );

  qfir_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .tap_ctl    (tap_ctl),
    .tap_sample (tap_sample),
    .tap_coef   (tap_coef),
    .done       (mac_done),
    .result     (mac_result)
  );

endmodule

>>> hdl/qfir_tap_mem.sv
// Delay-line and coefficient memories with the shift-on-read write-back path.
// Depends on qfir_pkg.
module qfir_tap_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              coef_we,
  input  qfir_pkg::addr_t   coef_addr,
  input  qfir_pkg::sample_t coef_data,
  input  logic              load_sample,
  input  qfir_pkg::sample_t sample_data,
  input  qfir_pkg::mac_ctl_t rd_ctl,
  input  qfir_pkg::addr_t   rd_addr,
  output qfir_pkg::mac_ctl_t tap_ctl,
  output qfir_pkg::sample_t tap_sample,
  output qfir_pkg::sample_t tap_coef
);
  import qfir_pkg::*;

  sample_t dl_mem [MAX_TAPS];
  sample_t cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] dl_vld_r;
  logic [MAX_TAPS-1:0] cf_vld_r;

  sample_t  dl_q_r;
  sample_t  cf_q_r;
  logic     dl_ok_r;
  logic     cf_ok_r;
  mac_ctl_t s1_ctl_r;
  addr_t    s1_addr_r;
  sample_t  carry_r;
  sample_t  dl_old;

  // Entries never written read as zero
  assign dl_old     = dl_ok_r ? dl_q_r : '0;
  assign tap_coef   = cf_ok_r ? cf_q_r : '0;
  assign tap_sample = carry_r;
  assign tap_ctl    = s1_ctl_r;

  // Registered reads; read address is always one ahead of the write address,
  // so a read and a write never hit the same entry in one cycle
  always_ff @(posedge clk) begin
    if (rd_ctl.vld) begin
      dl_q_r <= dl_mem[rd_addr];
      cf_q_r <= cf_mem[rd_addr];
    end
  end

  // Write ports: shifted delay value back to tap k, coefficient loads
  always_ff @(posedge clk) begin
    if (s1_ctl_r.vld) begin
      dl_mem[s1_addr_r] <= carry_r;
    end
    if (coef_we) begin
      cf_mem[coef_addr] <= coef_data;
    end
  end

  // Valid bits and read-stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_vld_r <= '0;
      cf_vld_r <= '0;
      s1_ctl_r <= '0;
      dl_ok_r  <= 1'b0;
      cf_ok_r  <= 1'b0;
    end else begin
      s1_ctl_r <= rd_ctl;
      if (rd_ctl.vld) begin
        dl_ok_r <= dl_vld_r[rd_addr];
        cf_ok_r <= cf_vld_r[rd_addr];
      end
      if (s1_ctl_r.vld) begin
        dl_vld_r[s1_addr_r] <= 1'b1;
      end
      if (coef_we) begin
        cf_vld_r[coef_addr] <= 1'b1;
      end
    end
  end

  // Carry holds the value that moves into the current tap
  always_ff @(posedge clk) begin
    s1_addr_r <= rd_addr;
    if (load_sample) begin
      carry_r <= sample_data;
    end else if (s1_ctl_r.vld) begin
      carry_r <= dl_old;
    end
  end

endmodule

>>> hdl/qfir_mac.sv
// Multiply-accumulate unit: registered 16x16 product, saturating 32-bit sum.
// Depends on qfir_pkg.
module qfir_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  qfir_pkg::mac_ctl_t tap_ctl,
  input  qfir_pkg::sample_t  tap_sample,
  input  qfir_pkg::sample_t  tap_coef,
  output logic               done,
  output qfir_pkg::sample_t  result
);
  import qfir_pkg::*;

  mac_ctl_t            ctl_a_r;
  acc_t                prod_r;
  acc_t                prod_nxt;
  acc_t                acc_r;
  acc_t                acc_base;
  acc_t                acc_nxt;
  logic signed [32:0]  sum;
  logic                done_r;

  assign prod_nxt = tap_sample * tap_coef;
  assign acc_base = ctl_a_r.first ? ACC_INIT : acc_r;
  assign sum      = {acc_base[31], acc_base} + {prod_r[31], prod_r};

  // Saturate when the 33-bit sum leaves the 32-bit range
  always_comb begin
    if (sum[32] == sum[31]) begin
      acc_nxt = sum[31:0];
    end else if (sum[32]) begin
      acc_nxt = ACC_MIN;
    end else begin
      acc_nxt = ACC_MAX;
    end
  end

  // Control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      done_r  <= 1'b0;
    end else begin
      ctl_a_r <= tap_ctl;
      done_r  <= ctl_a_r.vld && ctl_a_r.last;
    end
  end

  // Product and accumulator
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_a_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign done   = done_r;
  assign result = acc_r[30:15];

endmodule

>>> hdl/qfir_checker.sv
// Port-level checks for the Q15 FIR filter, bound to the top level.
// Depends on qfir_pkg, assert_macros.svh and q15_fir_filter.
`include "assert_macros.svh"

module qfir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_filtered
);
  import qfir_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result word stays up and unchanged
  `QFIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `QFIR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_filtered), "result changed while stalled")

  // A coefficient load never produces a result
  `QFIR_ASSERT_NEXT(a_coef_silent, in_acc && (in_mode == MODE_COEF) && !out_valid, !out_valid, "coefficient load produced a result")

  // A sample blocks new input and cannot produce its result the next cycle
  `QFIR_ASSERT_NEXT(a_sample_busy, in_acc && (in_mode == MODE_SAMPLE) && !out_valid, !in_ready && !out_valid, "sample did not start the tap loop")

endmodule

bind q15_fir_filter qfir_checker u_qfir_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_filtered (out_ch.filtered)
);
